// ===== src/assert_macros.svh =====
// Assertion macros shared by the status LED sequencer RTL.
// Used by files that `include this header; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted
`define SLPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slps assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define SLPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slps assertion failed");

`else

`define SLPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SLPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/slps_pkg.sv =====
// Shared types, codes, colors and lookup functions for the status LED sequencer.
// No dependencies; used by every RTL module of the block.
package slps_pkg;

  // Request command codes
  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_SET_MODE  = 2'd1,
    CMD_SET_LATCH = 2'd2,
    CMD_EVENT     = 2'd3
  } cmd_t;

  // System modes
  localparam logic [2:0] MODE_FACTORY      = 3'd0;
  localparam logic [2:0] MODE_BOOT_WINDOW  = 3'd1;
  localparam logic [2:0] MODE_BOOTLOADER   = 3'd2;
  localparam logic [2:0] MODE_RUNTIME_INIT = 3'd3;
  localparam logic [2:0] MODE_RUNTIME      = 3'd4;

  // Event kinds
  localparam logic [2:0] EV_WIFI_UP   = 3'd0;
  localparam logic [2:0] EV_WIFI_DOWN = 3'd1;
  localparam logic [2:0] EV_LINK_UP   = 3'd2;
  localparam logic [2:0] EV_LINK_DOWN = 3'd3;
  localparam logic [2:0] EV_PUBLISH   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_SYS_EN    = 2'd0;
  localparam logic [1:0] REG_USR_EN    = 2'd1;
  localparam logic [1:0] REG_BEAT_IV   = 2'd2;
  localparam logic [1:0] REG_FAST_IV   = 2'd3;

  // Register reset values
  localparam logic [15:0] BEAT_IV_RST = 16'd500;
  localparam logic [15:0] FAST_IV_RST = 16'd200;

  // Burst timing
  localparam logic [6:0] BURST_IV_STD   = 7'd100;
  localparam logic [6:0] BURST_IV_PUB   = 7'd80;
  localparam logic [6:0] BURST_EL_MAX   = 7'd127;
  localparam logic [2:0] BURST_TGL_STD  = 3'd7;
  localparam logic [2:0] BURST_TGL_PUB  = 3'd1;
  localparam logic [15:0] BEAT_EL_MAX   = 16'hFFFF;

  // Colors, 0xRRGGBB
  localparam logic [23:0] COL_BLACK  = 24'h000000;
  localparam logic [23:0] COL_RED    = 24'hFF0000;
  localparam logic [23:0] COL_ORANGE = 24'hFFA500;
  localparam logic [23:0] COL_GREEN  = 24'h008000;
  localparam logic [23:0] COL_CYAN   = 24'h00FFFF;
  localparam logic [23:0] COL_BLUE   = 24'h0000FF;
  localparam logic [23:0] COL_YELLOW = 24'hFFFF00;

  // Configuration as seen by the engine
  typedef struct packed {
    logic        sys_en;
    logic        usr_en;
    logic [15:0] beat_iv;
    logic [15:0] fast_iv;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [23:0] sys_rgb;
    logic [23:0] usr_rgb;
    logic        chg;
  } res_t;

  function automatic logic [23:0] mode_colour(logic [2:0] m);
    logic [23:0] c;
    case (m)
      MODE_FACTORY:      c = COL_RED;
      MODE_BOOT_WINDOW:  c = COL_ORANGE;
      MODE_BOOTLOADER:   c = COL_ORANGE;
      MODE_RUNTIME_INIT: c = COL_CYAN;
      MODE_RUNTIME:      c = COL_GREEN;
      default:           c = COL_BLACK;
    endcase
    return c;
  endfunction

  function automatic logic mode_beats(logic [2:0] m);
    return (m == MODE_FACTORY) || (m == MODE_BOOT_WINDOW) ||
           (m == MODE_BOOTLOADER) || (m == MODE_RUNTIME);
  endfunction

  function automatic logic [23:0] kind_colour(logic [2:0] k);
    logic [23:0] c;
    case (k)
      EV_WIFI_UP:   c = COL_GREEN;
      EV_WIFI_DOWN: c = COL_RED;
      EV_LINK_UP:   c = COL_BLUE;
      EV_LINK_DOWN: c = COL_ORANGE;
      default:      c = COL_YELLOW;
    endcase
    return c;
  endfunction

endpackage

// ===== src/slps_cfg_regs.sv =====
// Configuration register file: LED enables and heartbeat intervals.
// Depends on slps_pkg for register indexes, reset values and cfg_t.
module slps_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [15:0]        wr_data,
  output slps_pkg::cfg_t     cfg
);

  logic        sys_en_r,  sys_en_nxt;
  logic        usr_en_r,  usr_en_nxt;
  logic [15:0] beat_iv_r, beat_iv_nxt;
  logic [15:0] fast_iv_r, fast_iv_nxt;

  // Register write decode
  always_comb begin
    sys_en_nxt  = sys_en_r;
    usr_en_nxt  = usr_en_r;
    beat_iv_nxt = beat_iv_r;
    fast_iv_nxt = fast_iv_r;
    if (wr_en) begin
      case (wr_index)
        slps_pkg::REG_SYS_EN:  sys_en_nxt  = wr_data[0];
        slps_pkg::REG_USR_EN:  usr_en_nxt  = wr_data[0];
        slps_pkg::REG_BEAT_IV: beat_iv_nxt = wr_data;
        slps_pkg::REG_FAST_IV: fast_iv_nxt = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sys_en_r  <= 1'b1;
      usr_en_r  <= 1'b1;
      beat_iv_r <= slps_pkg::BEAT_IV_RST;
      fast_iv_r <= slps_pkg::FAST_IV_RST;
    end else begin
      sys_en_r  <= sys_en_nxt;
      usr_en_r  <= usr_en_nxt;
      beat_iv_r <= beat_iv_nxt;
      fast_iv_r <= fast_iv_nxt;
    end
  end

  assign cfg.sys_en  = sys_en_r;
  assign cfg.usr_en  = usr_en_r;
  assign cfg.beat_iv = beat_iv_r;
  assign cfg.fast_iv = fast_iv_r;

endmodule

// ===== src/slps_engine.sv =====
// Sequencer state (heartbeat, burst, latch, shown colors) and its one-request update.
// Depends on slps_pkg for codes, colors, cfg_t and res_t.
module slps_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  slps_pkg::cfg_t     cfg,
  input  logic [1:0]         cmd,
  input  logic [2:0]         mode,
  input  logic               latch,
  input  logic [2:0]         event_req,
  output slps_pkg::res_t     res
);

  logic [2:0]  mode_r,    mode_nxt;
  logic        beat_on_r, beat_on_nxt;
  logic [15:0] beat_el_r, beat_el_nxt;
  logic        latch_r,   latch_nxt;
  logic        b_act_r,   b_act_nxt;
  logic        b_on_r,    b_on_nxt;
  logic [6:0]  b_el_r,    b_el_nxt;
  logic [2:0]  b_kind_r,  b_kind_nxt;
  logic [2:0]  b_tgl_r,   b_tgl_nxt;
  logic [23:0] sys_rgb_r, sys_rgb_nxt;
  logic [23:0] usr_rgb_r, usr_rgb_nxt;

  logic        beats;
  logic [15:0] bint;
  logic [15:0] beat_inc;
  logic [6:0]  biv;
  logic [6:0]  b_inc;
  logic        chg;

  // Heartbeat interval and saturating counters
  assign beats    = slps_pkg::mode_beats(mode_r);
  assign bint     = (mode_r == slps_pkg::MODE_BOOT_WINDOW) ? cfg.fast_iv : cfg.beat_iv;
  assign beat_inc = (beat_el_r != slps_pkg::BEAT_EL_MAX) ? beat_el_r + 16'd1 : beat_el_r;
  assign biv      = (b_kind_r == slps_pkg::EV_PUBLISH) ? slps_pkg::BURST_IV_PUB
                                                        : slps_pkg::BURST_IV_STD;
  assign b_inc    = (b_el_r != slps_pkg::BURST_EL_MAX) ? b_el_r + 7'd1 : b_el_r;

  // Next state for one request
  always_comb begin
    mode_nxt    = mode_r;
    beat_on_nxt = beat_on_r;
    beat_el_nxt = beat_el_r;
    latch_nxt   = latch_r;
    b_act_nxt   = b_act_r;
    b_on_nxt    = b_on_r;
    b_el_nxt    = b_el_r;
    b_kind_nxt  = b_kind_r;
    b_tgl_nxt   = b_tgl_r;
    sys_rgb_nxt = sys_rgb_r;
    usr_rgb_nxt = usr_rgb_r;
    chg         = 1'b0;
    case (slps_pkg::cmd_t'(cmd))
      slps_pkg::CMD_TICK: begin
        // heartbeat
        if (beats) begin
          if (beat_inc >= bint) begin
            beat_on_nxt = ~beat_on_r;
            beat_el_nxt = '0;
          end else begin
            beat_el_nxt = beat_inc;
          end
        end else begin
          beat_on_nxt = 1'b1;
          beat_el_nxt = beat_inc;
        end
        sys_rgb_nxt = slps_pkg::COL_BLACK;
        if (cfg.sys_en) begin
          if (!beats || beat_on_nxt) sys_rgb_nxt = slps_pkg::mode_colour(mode_r);
        end
        // event burst
        if (b_act_r) begin
          if (b_inc >= biv) begin
            b_el_nxt  = '0;
            b_on_nxt  = ~b_on_r;
            b_tgl_nxt = (b_tgl_r != 3'd0) ? b_tgl_r - 3'd1 : b_tgl_r;
            if (b_tgl_nxt == 3'd0 && !b_on_nxt) b_act_nxt = 1'b0;
          end else begin
            b_el_nxt = b_inc;
          end
        end
        usr_rgb_nxt = slps_pkg::COL_BLACK;
        if (cfg.usr_en) begin
          if (b_act_nxt && b_on_nxt) usr_rgb_nxt = slps_pkg::kind_colour(b_kind_r);
          else if (latch_r)          usr_rgb_nxt = slps_pkg::COL_BLUE;
        end
        chg = (sys_rgb_nxt != sys_rgb_r) || (usr_rgb_nxt != usr_rgb_r);
      end
      slps_pkg::CMD_SET_MODE: begin
        // restart heartbeat so the next tick toggles at once
        mode_nxt    = mode;
        beat_el_nxt = slps_pkg::BEAT_EL_MAX;
        beat_on_nxt = 1'b0;
      end
      slps_pkg::CMD_SET_LATCH: begin
        latch_nxt = latch;
      end
      slps_pkg::CMD_EVENT: begin
        if (event_req <= slps_pkg::EV_PUBLISH) begin
          b_act_nxt  = 1'b1;
          b_on_nxt   = 1'b1;
          b_el_nxt   = '0;
          b_kind_nxt = event_req;
          b_tgl_nxt  = (event_req == slps_pkg::EV_PUBLISH) ? slps_pkg::BURST_TGL_PUB
                                                            : slps_pkg::BURST_TGL_STD;
        end
      end
      default: ;
    endcase
  end

  // State update on each request that passes through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= slps_pkg::MODE_RUNTIME;
      beat_on_r <= 1'b0;
      beat_el_r <= slps_pkg::BEAT_EL_MAX;
      latch_r   <= 1'b0;
      b_act_r   <= 1'b0;
      b_on_r    <= 1'b0;
      b_el_r    <= '0;
      b_kind_r  <= '0;
      b_tgl_r   <= '0;
      sys_rgb_r <= slps_pkg::COL_BLACK;
      usr_rgb_r <= slps_pkg::COL_BLACK;
    end else if (adv) begin
      mode_r    <= mode_nxt;
      beat_on_r <= beat_on_nxt;
      beat_el_r <= beat_el_nxt;
      latch_r   <= latch_nxt;
      b_act_r   <= b_act_nxt;
      b_on_r    <= b_on_nxt;
      b_el_r    <= b_el_nxt;
      b_kind_r  <= b_kind_nxt;
      b_tgl_r   <= b_tgl_nxt;
      sys_rgb_r <= sys_rgb_nxt;
      usr_rgb_r <= usr_rgb_nxt;
    end
  end

  assign res.sys_rgb = sys_rgb_nxt;
  assign res.usr_rgb = usr_rgb_nxt;
  assign res.chg     = chg;

endmodule

// ===== src/status_led_pattern_sequencer_core.sv =====
// Status LED pattern sequencer: accepts one request (tick, mode, latch or event) per
// clock and returns one result per request. A request is held in an input register,
// evaluated against the sequencer state in a single pass, and written to an output
// register once that register is free; out_valid then presents the result until it is
// taken. The sustained rate is one request per cycle; it drops only while the output
// register is held by out_ready low. Configuration writes are taken at any time and
// apply to every request evaluated after them, so they belong between requests with
// the block idle.
// Depends on slps_pkg, slps_cfg_regs, slps_engine and assert_macros.svh.
`include "assert_macros.svh"

module status_led_pattern_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [2:0]  in_mode,
  input  logic        in_latch,
  input  logic [2:0]  in_event_req,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_system_rgb,
  output logic [23:0] out_user_rgb,
  output logic        out_show_needed,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  slps_pkg::cfg_t cfg;
  slps_pkg::res_t res;

  logic        s1_valid_r, s1_valid_nxt;
  logic [1:0]  s1_cmd_r;
  logic [2:0]  s1_mode_r;
  logic        s1_latch_r;
  logic [2:0]  s1_ev_r;
  logic        out_valid_r, out_valid_nxt;
  slps_pkg::res_t out_res_r;

  logic in_fire, out_free, s1_adv;

  // Configuration registers
  assign cfg_ready = 1'b1;

  slps_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  // Pipeline flow control
  assign out_free      = !out_valid_r || out_ready;
  assign s1_adv        = s1_valid_r && out_free;
  assign in_ready      = !s1_valid_r || out_free;
  assign in_fire       = in_valid && in_ready;
  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r   <= in_cmd;
      s1_mode_r  <= in_mode;
      s1_latch_r <= in_latch;
      s1_ev_r    <= in_event_req;
    end
  end

  // Sequencer state and per-request evaluation
  slps_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (s1_adv),
    .cfg       (cfg),
    .cmd       (s1_cmd_r),
    .mode      (s1_mode_r),
    .latch     (s1_latch_r),
    .event_req (s1_ev_r),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (s1_adv) out_res_r <= res;
  end

  assign out_valid       = out_valid_r;
  assign out_system_rgb  = out_res_r.sys_rgb;
  assign out_user_rgb    = out_res_r.usr_rgb;
  assign out_show_needed = out_res_r.chg;

  // Checks
  `SLPS_ASSERT_IMP(a_ready_only_when_full, clk, rst_n, !in_ready, s1_valid_r && out_valid_r)
  `SLPS_ASSERT_NXT(a_adv_fills_out, clk, rst_n, s1_adv, out_valid_r)
  `SLPS_ASSERT_NXT(a_s1_holds, clk, rst_n, s1_valid_r && !out_free, s1_valid_r && $stable(s1_cmd_r))

endmodule

// ===== tb/slps_frame_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the status LED sequencer: tracks its own copy of the sequencer state,
// predicts the LED frame for every accepted request and compares it with the result channel.
// Depends on slps_pkg for command codes, modes, events, register indexes and colors.
module slps_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [2:0]  in_mode,
  input  logic        in_latch,
  input  logic [2:0]  in_event_req,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [23:0] out_system_rgb,
  input  logic [23:0] out_user_rgb,
  input  logic        out_show_needed,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  // Register copies
  logic        sys_en_q, usr_en_q;
  logic [15:0] beat_iv_q, fast_iv_q;

  // Sequencer state copies
  logic [2:0]  mode_q;
  logic        beat_on_q;
  logic [15:0] beat_el_q;
  logic        streaming_q;
  logic        burst_act_q, burst_on_q;
  logic [6:0]  burst_el_q;
  logic [2:0]  burst_kind_q;
  logic [2:0]  toggles_q;
  logic [23:0] shown_sys_q, shown_usr_q;

  // Frames predicted but not yet seen on the result channel
  slps_pkg::res_t expected_frames[$];

  function automatic logic [23:0] mode_hue(input logic [2:0] m);
    case (m)
      slps_pkg::MODE_FACTORY:      return slps_pkg::COL_RED;
      slps_pkg::MODE_BOOT_WINDOW,
      slps_pkg::MODE_BOOTLOADER:   return slps_pkg::COL_ORANGE;
      slps_pkg::MODE_RUNTIME_INIT: return slps_pkg::COL_CYAN;
      slps_pkg::MODE_RUNTIME:      return slps_pkg::COL_GREEN;
      default:                     return slps_pkg::COL_BLACK;
    endcase
  endfunction

  function automatic logic [23:0] burst_hue(input logic [2:0] k);
    case (k)
      slps_pkg::EV_WIFI_UP:   return slps_pkg::COL_GREEN;
      slps_pkg::EV_WIFI_DOWN: return slps_pkg::COL_RED;
      slps_pkg::EV_LINK_UP:   return slps_pkg::COL_BLUE;
      slps_pkg::EV_LINK_DOWN: return slps_pkg::COL_ORANGE;
      default:                return slps_pkg::COL_YELLOW;
    endcase
  endfunction

  task automatic clear_state();
    sys_en_q     = 1'b1;
    usr_en_q     = 1'b1;
    beat_iv_q    = slps_pkg::BEAT_IV_RST;
    fast_iv_q    = slps_pkg::FAST_IV_RST;
    mode_q       = slps_pkg::MODE_RUNTIME;
    beat_on_q    = 1'b0;
    beat_el_q    = slps_pkg::BEAT_EL_MAX;
    streaming_q  = 1'b0;
    burst_act_q  = 1'b0;
    burst_on_q   = 1'b0;
    burst_el_q   = '0;
    burst_kind_q = slps_pkg::EV_WIFI_UP;
    toggles_q    = '0;
    shown_sys_q  = slps_pkg::COL_BLACK;
    shown_usr_q  = slps_pkg::COL_BLACK;
  endtask

  // Advance the LED state by one request and return the frame it shows
  task automatic step_leds(input slps_pkg::cmd_t op, input logic [2:0] m, input logic l,
                           input logic [2:0] ev, output slps_pkg::res_t frame);
    logic        beats;
    logic [15:0] iv;
    logic [6:0]  biv;
    logic [23:0] sys, usr;
    frame.chg = 1'b0;
    case (op)
      slps_pkg::CMD_TICK: begin
        beats = (mode_q == slps_pkg::MODE_FACTORY) || (mode_q == slps_pkg::MODE_BOOT_WINDOW) ||
                (mode_q == slps_pkg::MODE_BOOTLOADER) || (mode_q == slps_pkg::MODE_RUNTIME);
        if (beat_el_q != slps_pkg::BEAT_EL_MAX) beat_el_q = beat_el_q + 16'd1;
        if (beats) begin
          iv = (mode_q == slps_pkg::MODE_BOOT_WINDOW) ? fast_iv_q : beat_iv_q;
          if (beat_el_q >= iv) begin
            beat_on_q = ~beat_on_q;
            beat_el_q = '0;
          end
        end else begin
          // steady modes keep the beat phase on
          beat_on_q = 1'b1;
        end

        sys = slps_pkg::COL_BLACK;
        if (sys_en_q) begin
          if (!beats || beat_on_q) sys = mode_hue(mode_q);
        end

        // burst: toggle at its interval, end once dark with no toggles left
        if (burst_act_q) begin
          biv = (burst_kind_q == slps_pkg::EV_PUBLISH) ? slps_pkg::BURST_IV_PUB
                                                       : slps_pkg::BURST_IV_STD;
          if (burst_el_q != slps_pkg::BURST_EL_MAX) burst_el_q = burst_el_q + 7'd1;
          if (burst_el_q >= biv) begin
            burst_el_q = '0;
            burst_on_q = ~burst_on_q;
            if (toggles_q != 3'd0) toggles_q = toggles_q - 3'd1;
            if (toggles_q == 3'd0 && !burst_on_q) burst_act_q = 1'b0;
          end
        end

        usr = slps_pkg::COL_BLACK;
        if (usr_en_q) begin
          if (burst_act_q && burst_on_q) usr = burst_hue(burst_kind_q);
          else if (streaming_q) usr = slps_pkg::COL_BLUE;
        end

        frame.chg   = (sys != shown_sys_q) || (usr != shown_usr_q);
        shown_sys_q = sys;
        shown_usr_q = usr;
      end
      slps_pkg::CMD_SET_MODE: begin
        mode_q    = m;
        beat_el_q = slps_pkg::BEAT_EL_MAX;
        beat_on_q = 1'b0;
      end
      slps_pkg::CMD_SET_LATCH: begin
        streaming_q = l;
      end
      default: begin
        // unknown event kinds leave the burst alone
        if (ev <= slps_pkg::EV_PUBLISH) begin
          burst_act_q  = 1'b1;
          burst_on_q   = 1'b1;
          burst_el_q   = '0;
          burst_kind_q = ev;
          toggles_q    = (ev == slps_pkg::EV_PUBLISH) ? slps_pkg::BURST_TGL_PUB
                                                      : slps_pkg::BURST_TGL_STD;
        end
      end
    endcase
    frame.sys_rgb = shown_sys_q;
    frame.usr_rgb = shown_usr_q;
  endtask

  task automatic report_mismatch(input string msg);
    if (fail_count < 100) $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    clear_state();
  end

  // Watch all three channels at the sampling edge
  always @(posedge clk) begin : watch
    slps_pkg::res_t predicted;
    slps_pkg::res_t oldest;
    if (!rst_n) begin
      clear_state();
      expected_frames.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          slps_pkg::REG_SYS_EN:  sys_en_q  = cfg_wdata[0];
          slps_pkg::REG_USR_EN:  usr_en_q  = cfg_wdata[0];
          slps_pkg::REG_BEAT_IV: beat_iv_q = cfg_wdata;
          slps_pkg::REG_FAST_IV: fast_iv_q = cfg_wdata;
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        step_leds(slps_pkg::cmd_t'(in_cmd), in_mode, in_latch, in_event_req, predicted);
        expected_frames.push_back(predicted);
      end

      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          report_mismatch($sformatf("result with no request outstanding (sys %h usr %h)",
                                    out_system_rgb, out_user_rgb));
        end else begin
          oldest = expected_frames.pop_front();
          checked++;
          if (out_system_rgb !== oldest.sys_rgb)
            report_mismatch($sformatf("result %0d system_rgb expected %h, got %h",
                                      checked, oldest.sys_rgb, out_system_rgb));
          if (out_user_rgb !== oldest.usr_rgb)
            report_mismatch($sformatf("result %0d user_rgb expected %h, got %h",
                                      checked, oldest.usr_rgb, out_user_rgb));
          if (out_show_needed !== oldest.chg)
            report_mismatch($sformatf("result %0d show_needed expected %b, got %b",
                                      checked, oldest.chg, out_show_needed));
        end
      end
    end
    pending = expected_frames.size();
  end

endmodule

// ===== tb/tb_status_led_pattern_sequencer_core.sv =====
`timescale 1ns / 1ps
// Top of the status LED sequencer testbench: clock, reset, request and config stimulus,
// result-channel back-pressure and the verdict. Depends on slps_pkg and slps_frame_checker.
module tb_status_led_pattern_sequencer_core;

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_ready;
  logic [1:0]  in_cmd;
  logic [2:0]  in_mode;
  logic        in_latch;
  logic [2:0]  in_event_req;
  logic        out_valid, out_ready;
  logic [23:0] out_system_rgb, out_user_rgb;
  logic        out_show_needed;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  int fail_count, pending, checked;

  // Back-pressure and gap knobs, in percent per cycle
  int send_idle_pct;
  int stall_pct;
  bit hold_off_req;
  int hold_cnt;

  // Run statistics
  int n_sent, n_ticks, n_modes, n_latches, n_events, n_cfg;

  status_led_pattern_sequencer_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_mode         (in_mode),
    .in_latch        (in_latch),
    .in_event_req    (in_event_req),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_system_rgb  (out_system_rgb),
    .out_user_rgb    (out_user_rgb),
    .out_show_needed (out_show_needed),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  slps_frame_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_mode         (in_mode),
    .in_latch        (in_latch),
    .in_event_req    (in_event_req),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_system_rgb  (out_system_rgb),
    .out_user_rgb    (out_user_rgb),
    .out_show_needed (out_show_needed),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .checked         (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result channel back-pressure; a hold-off request stalls it for a long stretch
  initial begin
    out_ready = 1'b0;
    hold_cnt  = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_cnt     = 60;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  // Send one request; fields the command does not use carry random bits
  task automatic issue(input slps_pkg::cmd_t op, input logic [2:0] arg);
    logic [2:0] m, ev;
    logic       l;
    m  = 3'($urandom);
    l  = 1'($urandom);
    ev = 3'($urandom);
    case (op)
      slps_pkg::CMD_SET_MODE:  m  = arg;
      slps_pkg::CMD_SET_LATCH: l  = arg[0];
      slps_pkg::CMD_EVENT:     ev = arg;
      default: ;
    endcase
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= op;
    in_mode      <= m;
    in_latch     <= l;
    in_event_req <= ev;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    n_sent++;
    case (op)
      slps_pkg::CMD_TICK:      n_ticks++;
      slps_pkg::CMD_SET_MODE:  n_modes++;
      slps_pkg::CMD_SET_LATCH: n_latches++;
      default:                 n_events++;
    endcase
  endtask

  // Stop offering requests until every predicted frame has come back
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    n_cfg++;
  endtask

  // Reprogram all registers with the block drained
  task automatic configure(input logic [15:0] sys_w, input logic [15:0] usr_w,
                           input logic [15:0] beat_w, input logic [15:0] fast_w);
    wait_all_results();
    repeat (4) @(negedge clk);
    write_reg(slps_pkg::REG_SYS_EN, sys_w);
    write_reg(slps_pkg::REG_USR_EN, usr_w);
    write_reg(slps_pkg::REG_BEAT_IV, beat_w);
    write_reg(slps_pkg::REG_FAST_IV, fast_w);
    cfg_valid <= 1'b0;
  endtask

  // Mixed traffic: tick runs dominate, with mode, latch and event requests between them
  task automatic random_traffic(input int n_items, input int hold_at, input int drain_at);
    int start, r;
    bit held, drained;
    start   = n_sent;
    held    = 1'b0;
    drained = 1'b0;
    while (n_sent - start < n_items) begin
      if (!held && hold_at >= 0 && n_sent - start >= hold_at) begin
        hold_off_req = 1'b1;
        held         = 1'b1;
      end
      if (!drained && drain_at >= 0 && n_sent - start >= drain_at) begin
        wait_all_results();
        drained = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 12)
        issue(slps_pkg::CMD_SET_MODE, ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4))
                                                                 : 3'($urandom_range(5, 7)));
      else if (r < 20)
        issue(slps_pkg::CMD_SET_LATCH, 3'($urandom));
      else if (r < 30)
        issue(slps_pkg::CMD_EVENT, ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4))
                                                              : 3'($urandom_range(5, 7)));
      else if (r < 34)
        issue(slps_pkg::cmd_t'(2'($urandom_range(0, 3))), 3'($urandom));
      else if (r < 40) begin
        // publish burst left to run to its end
        issue(slps_pkg::CMD_EVENT, slps_pkg::EV_PUBLISH);
        repeat ($urandom_range(80, 170)) issue(slps_pkg::CMD_TICK, '0);
      end else
        repeat ($urandom_range(1, 24)) issue(slps_pkg::CMD_TICK, '0);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = slps_pkg::CMD_TICK;
    in_mode       = '0;
    in_latch      = 1'b0;
    in_event_req  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = slps_pkg::REG_SYS_EN;
    cfg_wdata     = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_off_req  = 1'b0;
    n_sent = 0; n_ticks = 0; n_modes = 0; n_latches = 0; n_events = 0; n_cfg = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: first tick toggles at once, latch, every event kind, every mode
    issue(slps_pkg::CMD_TICK, '0);
    issue(slps_pkg::CMD_SET_LATCH, 3'd1);
    issue(slps_pkg::CMD_TICK, '0);
    issue(slps_pkg::CMD_EVENT, slps_pkg::EV_WIFI_UP);
    issue(slps_pkg::CMD_EVENT, slps_pkg::EV_WIFI_DOWN);
    issue(slps_pkg::CMD_EVENT, slps_pkg::EV_LINK_UP);
    issue(slps_pkg::CMD_EVENT, slps_pkg::EV_LINK_DOWN);
    issue(slps_pkg::CMD_EVENT, slps_pkg::EV_PUBLISH);
    issue(slps_pkg::CMD_EVENT, 3'd7);
    issue(slps_pkg::CMD_TICK, '0);
    issue(slps_pkg::CMD_SET_MODE, slps_pkg::MODE_FACTORY);
    issue(slps_pkg::CMD_TICK, '0);
    issue(slps_pkg::CMD_SET_MODE, slps_pkg::MODE_BOOT_WINDOW);
    issue(slps_pkg::CMD_TICK, '0);
    issue(slps_pkg::CMD_SET_MODE, slps_pkg::MODE_BOOTLOADER);
    issue(slps_pkg::CMD_TICK, '0);
    issue(slps_pkg::CMD_SET_MODE, slps_pkg::MODE_RUNTIME_INIT);
    issue(slps_pkg::CMD_TICK, '0);
    issue(slps_pkg::CMD_SET_MODE, slps_pkg::MODE_RUNTIME);
    issue(slps_pkg::CMD_TICK, '0);
    issue(slps_pkg::CMD_SET_MODE, 3'd5);
    issue(slps_pkg::CMD_TICK, '0);
    issue(slps_pkg::CMD_SET_MODE, 3'd7);
    issue(slps_pkg::CMD_TICK, '0);

    // Shortest intervals, zero fast interval; no idling, one long result stall
    configure(16'd1, 16'd1, 16'd1, 16'd0);
    send_idle_pct = 0;  stall_pct = 0;
    random_traffic(110, 60, -1);

    // System LED off; sender gaps, one full drain mid-phase
    configure(16'd0, 16'd1, 16'd3, 16'd2);
    send_idle_pct = 53; stall_pct = 0;
    random_traffic(110, -1, 55);

    // Longest intervals, user LED off (upper data bits set); receiver stalls
    configure(16'd1, 16'hFFFE, 16'hFFFF, 16'hFFFF);
    send_idle_pct = 0;  stall_pct = 53;
    random_traffic(110, -1, -1);

    // Random settings with light gaps on both sides
    configure(16'($urandom), 16'($urandom), 16'($urandom_range(1, 12)),
              16'($urandom_range(0, 12)));
    send_idle_pct = 7;  stall_pct = 7;
    random_traffic(110, -1, -1);

    // Full seven-toggle burst carried to its end, then a publish burst
    configure(16'd1, 16'd1, 16'd5, 16'd4);
    send_idle_pct = 0;  stall_pct = 0;
    issue(slps_pkg::CMD_EVENT, 3'($urandom_range(0, 3)));
    repeat (760) begin
      if ($urandom_range(0, 99) < 2) issue(slps_pkg::CMD_SET_LATCH, 3'($urandom));
      else if ($urandom_range(0, 99) < 2)
        issue(slps_pkg::CMD_SET_MODE, 3'($urandom_range(0, 4)));
      else issue(slps_pkg::CMD_TICK, '0);
    end
    issue(slps_pkg::CMD_EVENT, slps_pkg::EV_PUBLISH);
    repeat (100) issue(slps_pkg::CMD_TICK, '0);

    wait_all_results();
    repeat (8) @(negedge clk);

    $display("covered %0d requests (%0d ticks, %0d mode, %0d latch, %0d event)",
             n_sent, n_ticks, n_modes, n_latches, n_events);
    $display("with %0d register writes; compared %0d results, %0d mismatches",
             n_cfg, checked, fail_count);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/slps_pkg.sv
src/slps_cfg_regs.sv
src/slps_engine.sv
src/status_led_pattern_sequencer_core.sv
tb/slps_frame_checker.sv
tb/tb_status_led_pattern_sequencer_core.sv
